// ===== sv/bud_pkg.sv =====
// Shared types and constants of the buddy allocator.
// Payload structs, configuration indexes, status codes and inter-module structs.
// No dependencies.
`default_nettype none

package bud_pkg;

    localparam int LEN_W   = 26;
    localparam int BYTES_W = 27;
    localparam int NEED_W  = 27;
    localparam int POS_W   = 16;
    localparam int ORD_W   = 5;
    localparam int MB_CAP  = 16;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    localparam logic [1:0] CFG_MB     = 2'd0;
    localparam logic [1:0] CFG_POOL   = 2'd1;
    localparam logic [1:0] CFG_HEADER = 2'd2;

    typedef struct packed {
        logic             func;
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] offset;
    } bud_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [LEN_W-1:0]   block_offset;
        logic [BYTES_W-1:0] block_bytes;
    } bud_out_t;

    // Effective geometry, already saturated.
    typedef struct packed {
        logic [4:0] mb;
        logic [4:0] pool;
        logic [6:0] header;
    } geo_t;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_NOMEM,
        K_FREE,
        K_BADFREE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [ORD_W-1:0] ord;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] offset;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

`default_nettype wire

// ===== sv/bud_front.sv =====
// Front end of the buddy allocator: accepts transactions and classifies them.
// Depends on bud_pkg.
`default_nettype none

module bud_front (
    input  wire  bud_pkg::bud_in_t      in_data,
    input  wire  logic                  in_valid,
    output logic                        in_ready,
    input  wire  bud_pkg::geo_t         geo,
    input  wire  bud_pkg::back_status_t bstat,
    output logic                        q_push,
    input  wire  logic                  q_ready,
    output bud_pkg::cmd_t               q_data
);

    logic [bud_pkg::NEED_W-1:0] need;
    logic [bud_pkg::NEED_W-1:0] need_m1;
    logic [4:0]                 msb;
    logic [5:0]                 clog;
    logic [5:0]                 want;
    logic [bud_pkg::LEN_W-1:0]  leaf;
    logic                       misaligned;
    logic                       outside;

    assign in_ready = q_ready && !bstat.clearing;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        // Smallest order whose block covers the request plus its header.
        need    = bud_pkg::NEED_W'(in_data.length) + bud_pkg::NEED_W'(geo.header);
        need_m1 = need - bud_pkg::NEED_W'(1);
        msb     = '0;
        for (int i = 0; i < bud_pkg::NEED_W; i++)
        begin
            if (need_m1[i])
                msb = 5'(i);
        end
        clog = (need > bud_pkg::NEED_W'(1)) ? 6'(msb) + 6'd1 : 6'd0;
        want = (clog > 6'(geo.mb)) ? clog - 6'(geo.mb) : 6'd0;

        leaf       = in_data.offset >> geo.mb;
        misaligned = (in_data.offset & ~({bud_pkg::LEN_W{1'b1}} << geo.mb)) != '0;
        outside    = (32'(leaf) >> geo.pool) != 32'd0;

        q_data        = '0;
        q_data.offset = in_data.offset;
        q_data.pos    = bud_pkg::POS_W'(leaf);
        q_data.ord    = bud_pkg::ORD_W'(want);
        if (in_data.func == bud_pkg::FUNC_ALLOC)
        begin
            q_data.kind = (want > 6'(geo.pool)) ? bud_pkg::K_NOMEM : bud_pkg::K_ALLOC;
        end
        else
        begin
            q_data.kind = (misaligned || outside) ? bud_pkg::K_BADFREE : bud_pkg::K_FREE;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bud_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on bud_pkg.
`default_nettype none

module bud_queue (
    input  wire  logic          clk,
    input  wire  logic          rst_n,
    input  wire  logic          push,
    input  wire  bud_pkg::cmd_t push_data,
    output logic                ready,
    input  wire  logic          pop,
    output logic                valid,
    output bud_pkg::cmd_t       head
);

    bud_pkg::cmd_t ent_reg [2];
    logic [1:0]    count_reg, count_next;
    logic          rd_reg, rd_next;
    logic          wr_reg, wr_next;

    assign ready = count_reg != 2'd2;
    assign valid = count_reg != 2'd0;
    assign head  = ent_reg[rd_reg];

    always_comb
    begin
        rd_next    = pop ? !rd_reg : rd_reg;
        wr_next    = push ? !wr_reg : wr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== sv/bud_back.sv =====
// Back end of the buddy allocator: per-order free maps, leaf table, sequencer.
// Depends on bud_pkg.
`default_nettype none

module bud_back #(
    parameter int MAX_ORDER = 10
) (
    input  wire  logic                  clk,
    input  wire  logic                  rst_n,
    input  wire  bud_pkg::geo_t         geo,
    input  wire  logic                  geo_wr,
    input  wire  logic                  q_valid,
    input  wire  bud_pkg::cmd_t         q_data,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire  logic                  out_ready,
    output bud_pkg::bud_out_t           out_data,
    output bud_pkg::back_status_t       bstat
);

    localparam int LEAVES = 1 << MAX_ORDER;
    localparam int RW     = (LEAVES < 32) ? LEAVES : 32;
    localparam int LRW    = $clog2(RW);
    localparam int ROWS0  = LEAVES / RW;
    localparam int LA_W   = MAX_ORDER;
    localparam int OW     = $clog2(MAX_ORDER + 1);
    localparam int RIDX_W = (ROWS0 > 1) ? $clog2(ROWS0) : 1;

    function automatic int nrows(input int k);
        return ((LEAVES >> k) >= RW) ? ((LEAVES >> k) >> LRW) : 1;
    endfunction

    function automatic int row_base(input int k);
        int s;
        s = 0;
        for (int i = 0; i <= MAX_ORDER; i++)
        begin
            if (i < k)
                s = s + nrows(i);
        end
        return s;
    endfunction

    localparam int FROWS = row_base(MAX_ORDER + 1);
    localparam int FA_W  = (FROWS > 1) ? $clog2(FROWS) : 1;

    function automatic logic [ROWS0-1:0] row_mask(input int k);
        logic [ROWS0-1:0] m;
        for (int i = 0; i < ROWS0; i++)
            m[i] = i < nrows(k);
        return m;
    endfunction

    function automatic logic [RIDX_W-1:0] first_row(input logic [ROWS0-1:0] v);
        logic [RIDX_W-1:0] r;
        r = '0;
        for (int i = ROWS0 - 1; i >= 0; i--)
        begin
            if (v[i])
                r = RIDX_W'(i);
        end
        return r;
    endfunction

    function automatic logic [LRW-1:0] first_bit(input logic [RW-1:0] v);
        logic [LRW-1:0] r;
        r = '0;
        for (int i = RW - 1; i >= 0; i--)
        begin
            if (v[i])
                r = LRW'(i);
        end
        return r;
    endfunction

    function automatic logic [FA_W-1:0] row_addr(input logic [OW-1:0] k,
                                                  input logic [LA_W-1:0] j);
        return FA_W'(row_base(int'(k)) + int'(32'(j) >> LRW));
    endfunction

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAKE,
        S_SRD,
        S_SWR,
        S_LEAFW,
        S_FCHK,
        S_MRD,
        S_MCHK,
        S_SETWR,
        S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [OW-1:0]         k_reg, k_next;
    logic [OW-1:0]         want_reg, want_next;
    logic [LA_W-1:0]       pos_reg, pos_next;
    logic [RIDX_W-1:0]     row_reg, row_next;
    logic [FA_W-1:0]       addr_reg, addr_next;
    logic [LRW-1:0]        bsel_reg, bsel_next;
    logic [bud_pkg::LEN_W-1:0] off_reg, off_next;
    bud_pkg::bud_out_t     res_reg, res_next;
    bud_pkg::bud_out_t     out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [FROWS-1:0]      summ_reg, summ_next;
    logic                  clearing_reg, clearing_next;
    logic [LA_W-1:0]       cnt_reg, cnt_next;

    logic [RW-1:0]         fr_mem [FROWS];
    logic [RW-1:0]         fr_rdata_reg;
    logic [FA_W-1:0]       fr_raddr;
    logic                  fr_we;
    logic [FA_W-1:0]       fr_waddr;
    logic [RW-1:0]         fr_wdata;

    logic [OW:0]           lf_mem [LEAVES];
    logic [OW:0]           lf_rdata_reg;
    logic [LA_W-1:0]       lf_raddr;
    logic                  lf_we;
    logic [LA_W-1:0]       lf_waddr;
    logic [OW:0]           lf_wdata;

    logic                  found;
    logic [OW-1:0]         fk;
    logic [RIDX_W-1:0]     frow;
    logic [ROWS0-1:0]      slice;
    logic [LA_W-1:0]       j;
    logic [LA_W-1:0]       jj;
    logic [OW-1:0]         kd;
    logic [RW-1:0]         nrow;

    assign out_valid      = out_valid_reg;
    assign out_data       = out_reg;
    assign bstat.clearing = clearing_reg;
    assign q_pop          = state_reg == S_IDLE && !clearing_reg && q_valid;

    // Lowest order at or above the wanted one that holds a free block.
    always_comb
    begin
        found = 1'b0;
        fk    = '0;
        frow  = '0;
        for (int k = MAX_ORDER; k >= 0; k--)
        begin
            slice = ROWS0'(summ_reg >> row_base(k)) & row_mask(k);
            if (slice != '0 && k >= int'(q_data.ord) && k <= int'(geo.pool))
            begin
                found = 1'b1;
                fk    = OW'(k);
                frow  = first_row(slice);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        want_next      = want_reg;
        pos_next       = pos_reg;
        row_next       = row_reg;
        addr_next      = addr_reg;
        bsel_next      = bsel_reg;
        off_next       = off_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        summ_next      = summ_reg;
        clearing_next  = clearing_reg;
        cnt_next       = cnt_reg;
        fr_raddr       = addr_reg;
        fr_we          = 1'b0;
        fr_waddr       = addr_reg;
        fr_wdata       = '0;
        lf_raddr       = LA_W'(q_data.pos);
        lf_we          = 1'b0;
        lf_waddr       = pos_reg;
        lf_wdata       = '0;
        j              = '0;
        jj             = '0;
        kd             = '0;
        nrow           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    off_next  = q_data.offset;
                    want_next = OW'(q_data.ord);
                    pos_next  = LA_W'(q_data.pos);
                    res_next  = '0;
                    case (q_data.kind)
                        bud_pkg::K_NOMEM:
                        begin
                            res_next.status = bud_pkg::ST_NOMEM;
                            state_next      = S_OUT;
                        end
                        bud_pkg::K_BADFREE:
                        begin
                            res_next.status       = bud_pkg::ST_BADFREE;
                            res_next.block_offset = q_data.offset;
                            state_next            = S_OUT;
                        end
                        bud_pkg::K_ALLOC:
                        begin
                            if (found)
                            begin
                                k_next     = fk;
                                row_next   = frow;
                                addr_next  = FA_W'(row_base(int'(fk)) + int'(frow));
                                fr_raddr   = addr_next;
                                state_next = S_TAKE;
                            end
                            else
                            begin
                                res_next.status = bud_pkg::ST_NOMEM;
                                state_next      = S_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = S_FCHK;
                        end
                    endcase
                end
            end
            S_TAKE:
            begin
                j         = LA_W'((32'(row_reg) << LRW) | 32'(first_bit(fr_rdata_reg)));
                pos_next  = LA_W'(32'(j) << k_reg);
                nrow      = fr_rdata_reg & ~(RW'(1) << first_bit(fr_rdata_reg));
                fr_we     = 1'b1;
                fr_wdata  = nrow;
                summ_next[addr_reg] = |nrow;
                state_next = (k_reg == want_reg) ? S_LEAFW : S_SRD;
            end
            S_SRD:
            begin
                // Upper half of the block being split becomes free.
                kd         = k_reg - OW'(1);
                jj         = LA_W'((32'(pos_reg) >> kd) | 32'd1);
                k_next     = kd;
                addr_next  = row_addr(kd, jj);
                bsel_next  = jj[LRW-1:0];
                fr_raddr   = addr_next;
                state_next = S_SWR;
            end
            S_SWR:
            begin
                fr_we      = 1'b1;
                fr_wdata   = fr_rdata_reg | (RW'(1) << bsel_reg);
                summ_next[addr_reg] = 1'b1;
                state_next = (k_reg == want_reg) ? S_LEAFW : S_SRD;
            end
            S_LEAFW:
            begin
                lf_we                 = 1'b1;
                lf_wdata              = {1'b1, want_reg};
                res_next.status       = bud_pkg::ST_OK;
                res_next.block_offset = bud_pkg::LEN_W'(32'(pos_reg) << geo.mb);
                res_next.block_bytes  = bud_pkg::BYTES_W'(1) << (6'(geo.mb) + 6'(want_reg));
                state_next            = S_OUT;
            end
            S_FCHK:
            begin
                if (!lf_rdata_reg[OW])
                begin
                    res_next.status       = bud_pkg::ST_BADFREE;
                    res_next.block_offset = off_reg;
                    state_next            = S_OUT;
                end
                else
                begin
                    lf_we      = 1'b1;
                    lf_wdata   = '0;
                    k_next     = lf_rdata_reg[OW-1:0];
                    state_next = S_MRD;
                end
            end
            S_MRD:
            begin
                if (5'(k_reg) >= geo.pool)
                begin
                    jj         = LA_W'(32'(pos_reg) >> k_reg);
                    state_next = S_SETWR;
                end
                else
                begin
                    jj         = LA_W'((32'(pos_reg) >> k_reg) ^ 32'd1);
                    state_next = S_MCHK;
                end
                addr_next = row_addr(k_reg, jj);
                bsel_next = jj[LRW-1:0];
                fr_raddr  = addr_next;
            end
            S_MCHK:
            begin
                if (fr_rdata_reg[bsel_reg])
                begin
                    // Buddy is free: take it out of its map and move up one order.
                    nrow       = fr_rdata_reg & ~(RW'(1) << bsel_reg);
                    fr_we      = 1'b1;
                    fr_wdata   = nrow;
                    summ_next[addr_reg] = |nrow;
                    pos_next   = pos_reg & ~(LA_W'(1) << k_reg);
                    k_next     = k_reg + OW'(1);
                    state_next = S_MRD;
                end
                else
                begin
                    jj         = LA_W'(32'(pos_reg) >> k_reg);
                    addr_next  = row_addr(k_reg, jj);
                    bsel_next  = jj[LRW-1:0];
                    fr_raddr   = addr_next;
                    state_next = S_SETWR;
                end
            end
            S_SETWR:
            begin
                fr_we                 = 1'b1;
                fr_wdata              = fr_rdata_reg | (RW'(1) << bsel_reg);
                summ_next[addr_reg]   = 1'b1;
                res_next.status       = bud_pkg::ST_OK;
                res_next.block_offset = bud_pkg::LEN_W'(32'(pos_reg) << geo.mb);
                res_next.block_bytes  = bud_pkg::BYTES_W'(1) << (6'(geo.mb) + 6'(k_reg));
                state_next            = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Clearing pass: one free-map row and one leaf entry per cycle.
        if (clearing_reg)
        begin
            lf_we     = 1'b1;
            lf_waddr  = cnt_reg;
            lf_wdata  = '0;
            fr_we     = 32'(cnt_reg) < FROWS;
            fr_waddr  = FA_W'(cnt_reg);
            fr_wdata  = (32'(cnt_reg) == row_base(int'(geo.pool))) ? RW'(1) : '0;
            summ_next = FROWS'(1) << row_base(int'(geo.pool));
            cnt_next  = cnt_reg + LA_W'(1);
            if (cnt_reg == LA_W'(LEAVES - 1))
                clearing_next = 1'b0;
        end
        if (geo_wr)
        begin
            clearing_next = 1'b1;
            cnt_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            summ_reg      <= '0;
            clearing_reg  <= 1'b1;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            summ_reg      <= summ_next;
            clearing_reg  <= clearing_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        want_reg <= want_next;
        pos_reg  <= pos_next;
        row_reg  <= row_next;
        addr_reg <= addr_next;
        bsel_reg <= bsel_next;
        off_reg  <= off_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (fr_we)
            fr_mem[fr_waddr] <= fr_wdata;
        fr_rdata_reg <= fr_mem[fr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lf_we)
            lf_mem[lf_waddr] <= lf_wdata;
        lf_rdata_reg <= lf_mem[lf_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/buddy_allocator.sv =====
// Top level of the binary buddy allocator: configuration registers and block wiring.
// Depends on bud_pkg, bud_front, bud_queue and bud_back.
`default_nettype none

// The pool holds 2^pool_order minimum blocks of 2^min_block_log2 bytes. An
// allocate transaction adds header_bytes to its length, rounds up to a power of
// two and gets the lowest-addressed free block of the smallest order that fits,
// split down as needed; a free transaction returns a block and merges it with
// its free buddies. Every input transaction gives exactly one result. The front
// end classifies each transaction as it is accepted and places it in a two-entry
// queue; the back end works through it on per-order free maps kept as rows of
// up to 32 bits in one memory, with one flip-flop per row saying whether the row
// holds a free block. An allocate runs S_TAKE, then S_SRD and S_SWR per split
// level, then S_LEAFW; a free runs S_FCHK, then S_MRD and S_MCHK per merge
// level, then S_SETWR; each order level takes one read-modify-write of the
// free-map memory. Results wait in an output register, so a new transaction
// can enter the queue while a result is still waiting. After reset and after
// every write of min_block_log2 or pool_order, a clearing pass over all
// 2^MAX_ORDER leaf entries resets the free maps and the leaf table; no input
// transaction is accepted during that pass. Configuration writes are always
// accepted but must only be made while the block is idle.
module buddy_allocator #(
    parameter int MAX_ORDER = 10
) (
    input  wire  logic              clk,
    input  wire  logic              rst_n,
    input  wire  logic              in_valid,
    output logic                    in_ready,
    input  wire  bud_pkg::bud_in_t  in_data,
    output logic                    out_valid,
    input  wire  logic              out_ready,
    output bud_pkg::bud_out_t       out_data,
    input  wire  logic              cfg_valid,
    output logic                    cfg_ready,
    input  wire  logic [1:0]        cfg_index,
    input  wire  logic [6:0]        cfg_data
);

    logic [4:0] min_block_log2_reg, min_block_log2_next;
    logic [3:0] pool_order_reg, pool_order_next;
    logic [6:0] header_bytes_reg, header_bytes_next;
    logic       geo_wr;

    bud_pkg::geo_t         geo;
    bud_pkg::back_status_t bstat;
    bud_pkg::cmd_t         push_cmd;
    bud_pkg::cmd_t         head_cmd;
    logic                  q_push;
    logic                  q_ready;
    logic                  q_valid;
    logic                  q_pop;

    assign cfg_ready = 1'b1;

    // A change of geometry invalidates every block, so it restarts the clearing pass.
    assign geo_wr = cfg_valid && cfg_ready &&
                    (cfg_index == bud_pkg::CFG_MB || cfg_index == bud_pkg::CFG_POOL);

    always_comb
    begin
        min_block_log2_next = min_block_log2_reg;
        pool_order_next     = pool_order_reg;
        header_bytes_next   = header_bytes_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bud_pkg::CFG_MB:     min_block_log2_next = cfg_data[4:0];
                bud_pkg::CFG_POOL:   pool_order_next     = cfg_data[3:0];
                bud_pkg::CFG_HEADER: header_bytes_next   = cfg_data;
                default:             header_bytes_next   = header_bytes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_block_log2_reg <= 5'd7;
            pool_order_reg     <= 4'd10;
            header_bytes_reg   <= 7'd16;
        end
        else
        begin
            min_block_log2_reg <= min_block_log2_next;
            pool_order_reg     <= pool_order_next;
            header_bytes_reg   <= header_bytes_next;
        end
    end

    // The minimum block is capped at 64 KiB and the pool at the built-in depth.
    always_comb
    begin
        geo.mb     = (min_block_log2_reg > 5'(bud_pkg::MB_CAP)) ?
                     5'(bud_pkg::MB_CAP) : min_block_log2_reg;
        geo.pool   = (32'(pool_order_reg) > MAX_ORDER) ? 5'(MAX_ORDER) : 5'(pool_order_reg);
        geo.header = header_bytes_reg;
    end

    bud_front u_front (
        .in_data  (in_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .geo      (geo),
        .bstat    (bstat),
        .q_push   (q_push),
        .q_ready  (q_ready),
        .q_data   (push_cmd)
    );

    bud_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_cmd)
    );

    bud_back #(
        .MAX_ORDER (MAX_ORDER)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .geo       (geo),
        .geo_wr    (geo_wr),
        .q_valid   (q_valid),
        .q_data    (head_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .bstat     (bstat)
    );

    // No transaction may enter while the stores are being cleared.
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.clearing |-> !in_ready)
        else $error("input accepted during clearing pass");

    // A geometry write always starts a clearing pass.
    a_geo_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
        geo_wr |=> bstat.clearing)
        else $error("geometry write did not start clearing");

    // A failed allocation reports no block.
    a_nomem_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == bud_pkg::ST_NOMEM) |->
        (out_data.block_offset == '0 && out_data.block_bytes == '0))
        else $error("no-memory result carries a block");

endmodule

`default_nettype wire
